// File: hw/rtl/ewmc_pkg.sv
`default_nettype none

package ewmc_pkg;

  localparam int unsigned SampleW    = 32;
  localparam int unsigned AlphaFracW = 16;
  localparam int unsigned AlphaRegW  = 17;
  localparam int unsigned WordW      = 32;
  localparam int unsigned ProdW      = 2 * WordW;
  localparam int unsigned MomW       = 64;
  localparam int unsigned StepW      = 5;

  localparam logic [AlphaRegW-1:0] AlphaReset = AlphaRegW'(6242);
  localparam logic [AlphaFracW:0]  AlphaOne   = {1'b1, {AlphaFracW{1'b0}}};
  localparam logic [ProdW-1:0]     HalfLsb    = ProdW'(1) << (AlphaFracW - 1);
  localparam logic [MomW-1:0]      PosMax     = {1'b0, {(MomW-1){1'b1}}};
  localparam logic [MomW-1:0]      NegMax     = {1'b1, {(MomW-1){1'b0}}};

  typedef logic [StepW-1:0] step_t;

  localparam step_t LoadStep = StepW'(22);
  localparam step_t LastStep = StepW'(22);

  typedef struct packed {
    logic signed [31:0] x_sample;
    logic signed [31:0] y_sample;
    logic               start_series;
    logic               end_series;
  } in_word_t;

  typedef struct packed {
    logic        [62:0] var_x_out;
    logic signed [63:0] cov_xy_out;
    logic        [62:0] var_y_out;
    logic               is_final;
  } out_word_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_A_AX,
    MUL_A_AY,
    MUL_AX_AX,
    MUL_AY_AY,
    MUL_AX_AY,
    MUL_A_PHI,
    MUL_A_OPLO,
    MUL_B_OPHI,
    MUL_B_OPLO
  } mul_sel_e;

  typedef enum logic {
    ACC_HOLD,
    ACC_LOAD_HI
  } acc_op_e;

  typedef enum logic [2:0] {
    OPL_NONE,
    OPL_PROD,
    OPL_SUM_VX,
    OPL_SUM_VY,
    OPL_SUM_COV
  } opl_e;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_DEV,
    WB_MX,
    WB_MY,
    WB_VX,
    WB_VY,
    WB_COV,
    WB_LOAD
  } wb_e;

  typedef enum logic [1:0] {
    CTL_NEXT,
    CTL_JRESTART,
    CTL_DONE
  } ctl_e;

  typedef struct packed {
    mul_sel_e mul;
    acc_op_e  acc;
    opl_e     opl;
    wb_e      wb;
    ctl_e     ctl;
    step_t    target;
  } ctrl_t;

  // microprogram rom
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c = '{mul: MUL_NONE, acc: ACC_HOLD, opl: OPL_NONE, wb: WB_NONE,
          ctl: CTL_NEXT, target: LoadStep};
    case (s)
      StepW'(0): begin
        c.wb  = WB_DEV;
        c.ctl = CTL_JRESTART;
      end
      StepW'(1): begin
        c.mul = MUL_A_AX;
      end
      StepW'(2): begin
        c.mul = MUL_A_AY;
        c.wb  = WB_MX;
      end
      StepW'(3): begin
        c.mul = MUL_AX_AX;
        c.wb  = WB_MY;
      end
      // variance of x
      StepW'(4): begin
        c.mul = MUL_A_PHI;
        c.opl = OPL_PROD;
      end
      StepW'(5): begin
        c.mul = MUL_A_OPLO;
        c.acc = ACC_LOAD_HI;
      end
      StepW'(6): begin
        c.opl = OPL_SUM_VX;
      end
      StepW'(7): begin
        c.mul = MUL_B_OPHI;
      end
      StepW'(8): begin
        c.mul = MUL_B_OPLO;
        c.acc = ACC_LOAD_HI;
      end
      StepW'(9): begin
        c.mul = MUL_AY_AY;
        c.wb  = WB_VX;
      end
      // variance of y
      StepW'(10): begin
        c.mul = MUL_A_PHI;
        c.opl = OPL_PROD;
      end
      StepW'(11): begin
        c.mul = MUL_A_OPLO;
        c.acc = ACC_LOAD_HI;
      end
      StepW'(12): begin
        c.opl = OPL_SUM_VY;
      end
      StepW'(13): begin
        c.mul = MUL_B_OPHI;
      end
      StepW'(14): begin
        c.mul = MUL_B_OPLO;
        c.acc = ACC_LOAD_HI;
      end
      StepW'(15): begin
        c.mul = MUL_AX_AY;
        c.wb  = WB_VY;
      end
      // covariance
      StepW'(16): begin
        c.mul = MUL_A_PHI;
        c.opl = OPL_PROD;
      end
      StepW'(17): begin
        c.mul = MUL_A_OPLO;
        c.acc = ACC_LOAD_HI;
      end
      StepW'(18): begin
        c.opl = OPL_SUM_COV;
      end
      StepW'(19): begin
        c.mul = MUL_B_OPHI;
      end
      StepW'(20): begin
        c.mul = MUL_B_OPLO;
        c.acc = ACC_LOAD_HI;
      end
      StepW'(21): begin
        c.wb  = WB_COV;
        c.ctl = CTL_DONE;
      end
      StepW'(22): begin
        c.wb  = WB_LOAD;
        c.ctl = CTL_DONE;
      end
      default: begin
        c.ctl = CTL_DONE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ewmc_datapath.sv
`default_nettype none

module ewmc_datapath (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 go_i,
  input  ewmc_pkg::ctrl_t     ctrl_i,
  input  ewmc_pkg::in_word_t  item_i,
  input  wire [16:0]          alpha_i,
  output logic                restart_o,
  output ewmc_pkg::out_word_t res_o
);
  import ewmc_pkg::*;

  logic [SampleW-1:0] mx_q, my_q, mx_d, my_d;
  logic [SampleW:0]   dx_q, dy_q, dx_d, dy_d;
  logic [MomW-2:0]    vx_q, vy_q, vx_d, vy_d;
  logic [MomW-1:0]    cov_q, cov_d;
  logic [ProdW-1:0]   p_q, p_d;
  logic [MomW-1:0]    acc_q, op_q, op_d;
  logic               sgn_q, sgn_d;
  logic               primed_q, primed_d;

  logic [AlphaFracW:0] a_f, b_f;
  logic [WordW-1:0]    a_w, b_w, ml, mr;
  logic [SampleW:0]    ax_full, ay_full;
  logic [SampleW-1:0]  ax, ay;
  logic [ProdW-1:0]    rnd, hi_sh;
  logic [MomW-1:0]     acc_nx;
  logic [SampleW:0]    rnd_n;
  logic [MomW-2:0]     v_sel;
  logic [MomW:0]       v_sum;
  logic                cn, tn, sn;
  logic [MomW-1:0]     cm, sm;
  logic [MomW:0]       c_add, c_sub;

  assign a_f = (alpha_i > AlphaOne) ? AlphaOne : alpha_i;
  assign b_f = AlphaOne - a_f;
  assign a_w = {{(WordW-AlphaFracW-1){1'b0}}, a_f};
  assign b_w = {{(WordW-AlphaFracW-1){1'b0}}, b_f};

  assign ax_full = dx_q[SampleW] ? (~dx_q + 1'b1) : dx_q;
  assign ay_full = dy_q[SampleW] ? (~dy_q + 1'b1) : dy_q;
  assign ax      = ax_full[SampleW-1:0];
  assign ay      = ay_full[SampleW-1:0];

  always_comb begin
    ml = '0;
    mr = '0;
    case (ctrl_i.mul)
      MUL_A_AX: begin
        ml = a_w;
        mr = ax;
      end
      MUL_A_AY: begin
        ml = a_w;
        mr = ay;
      end
      MUL_AX_AX: begin
        ml = ax;
        mr = ax;
      end
      MUL_AY_AY: begin
        ml = ay;
        mr = ay;
      end
      MUL_AX_AY: begin
        ml = ax;
        mr = ay;
      end
      MUL_A_PHI: begin
        ml = a_w;
        mr = p_q[ProdW-1:WordW];
      end
      MUL_A_OPLO: begin
        ml = a_w;
        mr = op_q[WordW-1:0];
      end
      MUL_B_OPHI: begin
        ml = b_w;
        mr = op_q[MomW-1:WordW];
      end
      MUL_B_OPLO: begin
        ml = b_w;
        mr = op_q[WordW-1:0];
      end
      default: begin
        ml = '0;
        mr = '0;
      end
    endcase
  end

  assign p_d    = {{WordW{1'b0}}, ml} * {{WordW{1'b0}}, mr};
  assign rnd    = (p_q + HalfLsb) >> AlphaFracW;
  assign hi_sh  = p_q << (WordW - AlphaFracW);
  assign acc_nx = acc_q + rnd;
  assign rnd_n  = rnd[SampleW:0];

  // saturating variance sum
  assign v_sel = (ctrl_i.opl == OPL_SUM_VY) ? vy_q : vx_q;
  assign v_sum = {2'b00, v_sel} + {1'b0, acc_nx};

  // signed covariance sum on magnitudes
  assign cn    = cov_q[MomW-1];
  assign cm    = cn ? (~cov_q + 1'b1) : cov_q;
  assign tn    = dx_q[SampleW] ^ dy_q[SampleW];
  assign c_add = {1'b0, cm} + {1'b0, acc_nx};
  assign c_sub = {1'b0, cm} - {1'b0, acc_nx};

  always_comb begin
    if (cn == tn) begin
      sn = cn;
      sm = c_add[MomW] ? {MomW{1'b1}} : c_add[MomW-1:0];
    end else if (!c_sub[MomW]) begin
      sn = cn;
      sm = c_sub[MomW-1:0];
    end else begin
      sn = tn;
      sm = acc_nx - cm;
    end
  end

  always_comb begin
    op_d  = op_q;
    sgn_d = sgn_q;
    case (ctrl_i.opl)
      OPL_PROD: begin
        op_d = p_q;
      end
      OPL_SUM_VX, OPL_SUM_VY: begin
        op_d = (v_sum[MomW:MomW-1] != 2'b00) ? PosMax : v_sum[MomW-1:0];
      end
      OPL_SUM_COV: begin
        if (sn) begin
          op_d  = (sm > NegMax) ? NegMax : sm;
          sgn_d = (sm != '0);
        end else begin
          op_d  = (sm > PosMax) ? PosMax : sm;
          sgn_d = 1'b0;
        end
      end
      default: begin
        op_d = op_q;
      end
    endcase
  end

  always_comb begin
    mx_d     = mx_q;
    my_d     = my_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    vx_d     = vx_q;
    vy_d     = vy_q;
    cov_d    = cov_q;
    primed_d = primed_q;
    case (ctrl_i.wb)
      WB_DEV: begin
        dx_d = {item_i.x_sample[SampleW-1], item_i.x_sample} - {mx_q[SampleW-1], mx_q};
        dy_d = {item_i.y_sample[SampleW-1], item_i.y_sample} - {my_q[SampleW-1], my_q};
      end
      WB_MX: begin
        mx_d = dx_q[SampleW] ? (mx_q - rnd_n[SampleW-1:0]) : (mx_q + rnd_n[SampleW-1:0]);
      end
      WB_MY: begin
        my_d = dy_q[SampleW] ? (my_q - rnd_n[SampleW-1:0]) : (my_q + rnd_n[SampleW-1:0]);
      end
      WB_VX: begin
        vx_d = acc_nx[MomW-2:0];
      end
      WB_VY: begin
        vy_d = acc_nx[MomW-2:0];
      end
      WB_COV: begin
        cov_d = sgn_q ? (~acc_nx + 1'b1) : acc_nx;
      end
      WB_LOAD: begin
        mx_d     = item_i.x_sample;
        my_d     = item_i.y_sample;
        vx_d     = '0;
        vy_d     = '0;
        cov_d    = '0;
        primed_d = 1'b1;
      end
      default: begin
        mx_d = mx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
    end else if (go_i) begin
      primed_q <= primed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      if (ctrl_i.mul != MUL_NONE) begin
        p_q <= p_d;
      end
      if (ctrl_i.acc == ACC_LOAD_HI) begin
        acc_q <= hi_sh;
      end
      op_q  <= op_d;
      sgn_q <= sgn_d;
      mx_q  <= mx_d;
      my_q  <= my_d;
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      vx_q  <= vx_d;
      vy_q  <= vy_d;
      cov_q <= cov_d;
    end
  end

  assign restart_o = item_i.start_series || !primed_q;

  assign res_o.var_x_out  = vx_d;
  assign res_o.cov_xy_out = cov_d;
  assign res_o.var_y_out  = vy_d;
  assign res_o.is_final   = item_i.end_series;

endmodule

`default_nettype wire

// File: hw/rtl/ewm_covariance_tracker.sv
// Exponentially weighted variance and covariance tracker for paired samples.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_data_i carrying alpha as
// unsigned Q0.16 (65536 is one, larger values act as one); always ready,
// write it only while no word is in flight. Reset value is 6242.
// Input channel: in_valid_i/in_stall_o, one word holds x, y (signed Q16.16)
// and the start and end marks. Output channel: out_valid_o/out_stall_i, one
// word per input with both variances and the covariance in Q32.32 plus the
// end mark echoed as is_final.
// A word that carries the start mark, or is the first after reset,
// restarts the estimates and jumps from step 0 to the load step. A
// tracking word walks 22 steps of the microprogram, which issue 17
// products through one shared 32x32 multiplier. A new word is taken
// only after the result of the last one is written to the output
// register.
// Reset clears the primed flag and empties the output register. While the
// receiver stalls, the result waits in the output register and a new word
// can still be processed; the sequencer then holds at its final step until
// the output register is free.
`default_nettype none

module ewm_covariance_tracker (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire [16:0]           cfg_data_i,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  ewmc_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output ewmc_pkg::out_word_t  out_data_o
);
  import ewmc_pkg::*;

  logic                 busy_q, busy_d;
  step_t                pc_q, pc_d;
  in_word_t             item_q;
  logic [AlphaRegW-1:0] alpha_q;
  logic                 out_valid_q;
  out_word_t            out_q;
  ctrl_t                ctrl;
  logic                 in_acc, out_free, go, done, restart;
  out_word_t            res;

  assign ctrl     = ucode(pc_q);
  assign in_stall_o  = busy_q;
  assign in_acc   = in_valid_i && !busy_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign done     = ctrl.ctl == CTL_DONE;
  assign go       = busy_q && (!done || out_free);

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  ewmc_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (go),
    .ctrl_i    (ctrl),
    .item_i    (item_q),
    .alpha_i   (alpha_q),
    .restart_o (restart),
    .res_o     (res)
  );

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (in_acc) begin
      pc_d   = '0;
      busy_d = 1'b1;
    end else if (go) begin
      case (ctrl.ctl)
        CTL_NEXT: begin
          pc_d = pc_q + 1'b1;
        end
        CTL_JRESTART: begin
          pc_d = restart ? ctrl.target : (pc_q + 1'b1);
        end
        CTL_DONE: begin
          busy_d = 1'b0;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      alpha_q     <= AlphaReset;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
      if (cfg_valid_i) begin
        alpha_q <= cfg_data_i;
      end
      if (go && done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
    if (go && done) begin
      out_q <= res;
    end
  end

  a_acc_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q && pc_q == '0)
    else $error("sequencer did not start at step zero");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pc_q <= LastStep)
    else $error("step counter left the program");

  a_done_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> out_valid_q)
    else $error("word finished without a result");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(go && done))
    else $error("result appeared outside the final step");

endmodule

`default_nettype wire

// File: dv/ewm_moment_checker.sv
module ewm_moment_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [16:0]         cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  ewmc_pkg::in_word_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  ewmc_pkg::out_word_t out_data_i,
  output int                  pending_o,
  output int                  errors_o
);
  import ewmc_pkg::*;

  logic [AlphaRegW-1:0] alpha_reg;
  longint               mean_x;
  longint               mean_y;
  logic [63:0]          var_x;
  logic [63:0]          var_y;
  longint               cov_xy;
  bit                   primed;
  out_word_t            moments_q[$];
  int                   mismatches = 0;

  assign errors_o = mismatches;

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint to_signed_sat(input bit neg, input logic [63:0] m);
    if (!neg) return (m > PosMax) ? longint'(PosMax) : longint'(m);
    if (m >= NegMax) return longint'(NegMax);
    return -longint'(m);
  endfunction

  // round half away from zero at the alpha binary point, factor clamped to one
  function automatic logic [63:0] scale_round(input logic [63:0] m, input logic [16:0] f);
    logic [63:0] f64;
    logic [63:0] hi;
    logic [63:0] lo;
    if (f >= AlphaOne) return m;
    f64 = 64'(f);
    hi = (f64 * (m >> 32)) << (32 - AlphaFracW);
    lo = (f64 * {32'd0, m[31:0]} + HalfLsb) >> AlphaFracW;
    return hi + lo;
  endfunction

  function automatic logic [63:0] mul_clip(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return (p[127:64] != 64'd0) ? {64{1'b1}} : p[63:0];
  endfunction

  function automatic logic [63:0] var_step(input logic [63:0] v, input logic [63:0] ad,
                                           input logic [16:0] a, input logic [16:0] b);
    logic [63:0] t;
    logic [63:0] s;
    t = scale_round(mul_clip(ad, ad), a);
    s = (t > PosMax - v) ? PosMax : v + t;
    return scale_round(s, b);
  endfunction

  function automatic out_word_t track_sample(input in_word_t w);
    out_word_t   r;
    logic [16:0] a;
    logic [16:0] b;
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    longint      s;
    logic [63:0] step;
    logic [63:0] tm;
    logic [63:0] cm;
    logic [63:0] sm;
    bit          tn;
    bit          cn;
    bit          sn;
    x = longint'(w.x_sample);
    y = longint'(w.y_sample);
    a = (alpha_reg > AlphaOne) ? 17'(AlphaOne) : alpha_reg;
    b = 17'(AlphaOne) - a;
    if (w.start_series || !primed) begin
      mean_x = x;
      mean_y = y;
      var_x = '0;
      var_y = '0;
      cov_xy = 0;
      primed = 1'b1;
    end else begin
      dx = x - mean_x;
      dy = y - mean_y;
      step = scale_round(magnitude(dx), a);
      mean_x = (dx < 0) ? mean_x - longint'(step) : mean_x + longint'(step);
      step = scale_round(magnitude(dy), a);
      mean_y = (dy < 0) ? mean_y - longint'(step) : mean_y + longint'(step);
      var_x = var_step(var_x, magnitude(dx), a, b);
      var_y = var_step(var_y, magnitude(dy), a, b);
      tm = scale_round(mul_clip(magnitude(dx), magnitude(dy)), a);
      tn = (dx < 0) != (dy < 0);
      cn = cov_xy < 0;
      cm = magnitude(cov_xy);
      if (cn == tn) begin
        sn = cn;
        sm = (tm > ~cm) ? {64{1'b1}} : cm + tm;
      end else if (cm >= tm) begin
        sn = cn;
        sm = cm - tm;
      end else begin
        sn = tn;
        sm = tm - cm;
      end
      s = to_signed_sat(sn, sm);
      cov_xy = to_signed_sat(s < 0, scale_round(magnitude(s), b));
    end
    r.var_x_out = var_x[62:0];
    r.cov_xy_out = cov_xy;
    r.var_y_out = var_y[62:0];
    r.is_final = w.end_series;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch in %s at %0t: got %h, want %h", what, $time, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      alpha_reg = AlphaReset;
      mean_x = 0;
      mean_y = 0;
      var_x = '0;
      var_y = '0;
      cov_xy = 0;
      primed = 1'b0;
      moments_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) alpha_reg = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (moments_q.size() == 0) begin
          flag_mismatch("unexpected word", 64'(out_data_i.var_x_out), 64'd0);
        end else begin
          want = moments_q.pop_front();
          if (out_data_i.var_x_out !== want.var_x_out)
            flag_mismatch("var_x", 64'(out_data_i.var_x_out), 64'(want.var_x_out));
          if (out_data_i.cov_xy_out !== want.cov_xy_out)
            flag_mismatch("cov_xy", out_data_i.cov_xy_out, want.cov_xy_out);
          if (out_data_i.var_y_out !== want.var_y_out)
            flag_mismatch("var_y", 64'(out_data_i.var_y_out), 64'(want.var_y_out));
          if (out_data_i.is_final !== want.is_final)
            flag_mismatch("is_final", 64'(out_data_i.is_final), 64'(want.is_final));
        end
      end
      if (in_valid_i && !in_stall_i) moments_q = {moments_q, track_sample(in_data_i)};
      pending_o <= moments_q.size();
    end
  end

endmodule

// File: dv/ewm_covariance_tracker_tb.sv
module ewm_covariance_tracker_tb;
  import ewmc_pkg::*;

  localparam int HoldCycles = 250;
  localparam int PhaseItems = 125;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  int          pending;
  int          errors;

  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  bit          hold_req = 1'b0;

  always #4 clk = ~clk;

  ewm_covariance_tracker DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  ewm_moment_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  function automatic in_word_t pair(input logic signed [31:0] x, input logic signed [31:0] y,
                                    input bit s, input bit e);
    in_word_t w;
    w.x_sample = x;
    w.y_sample = y;
    w.start_series = s;
    w.end_series = e;
    return w;
  endfunction

  function automatic logic signed [31:0] corner(input int k);
    case (k)
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh0;
      default: return -32'sd1;
    endcase
  endfunction

  task automatic send_pair(input in_word_t w);
    if (tx_idle && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_alpha(input logic [16:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // receiver
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end
      out_stall <= rx_idle && ($urandom_range(0, 99) < 28);
    end
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic [16:0]        alpha_pick;
    int                 left;
    int                 flavor;
    int                 spread;
    bit                 first;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset alpha, start on the very first word
    send_pair(pair(32'sh7fffffff, 32'sh80000000, 1'b1, 1'b0));
    send_pair(pair(32'sh80000000, 32'sh7fffffff, 1'b0, 1'b0));
    send_pair(pair(32'sh0, 32'sh0, 1'b0, 1'b0));
    send_pair(pair(32'sh7fffffff, 32'sh7fffffff, 1'b0, 1'b1));
    send_pair(pair(32'sd1, -32'sd1, 1'b0, 1'b0));
    send_pair(pair(-32'sd1, 32'sd1, 1'b1, 1'b1));
    send_pair(pair(32'sh80000000, 32'sh80000000, 1'b0, 1'b0));
    settle();
    write_alpha(17'(AlphaOne));
    send_pair(pair(32'sh50000, -32'sh30000, 1'b1, 1'b0));
    send_pair(pair(32'sh7fffffff, 32'sh80000000, 1'b0, 1'b0));
    send_pair(pair(-32'sd7, 32'sd9, 1'b0, 1'b1));
    settle();
    // alpha above one
    write_alpha(17'h1ffff);
    send_pair(pair(32'sh80000000, 32'sh7fffffff, 1'b0, 1'b0));
    send_pair(pair(32'sh0, 32'sh0, 1'b0, 1'b1));
    settle();
    write_alpha('0);
    send_pair(pair(32'sh7fffffff, 32'sh80000000, 1'b0, 1'b0));
    send_pair(pair(32'sh80000000, 32'sh7fffffff, 1'b0, 1'b1));
    settle();
    // moments pushed into saturation
    write_alpha(17'd65535);
    send_pair(pair(32'sh7fffffff, 32'sh80000000, 1'b1, 1'b0));
    send_pair(pair(32'sh80000000, 32'sh7fffffff, 1'b0, 1'b0));
    send_pair(pair(32'sh7fffffff, 32'sh80000000, 1'b0, 1'b0));
    send_pair(pair(32'sh80000000, 32'sh7fffffff, 1'b0, 1'b0));
    send_pair(pair(32'sh7fffffff, 32'sh80000000, 1'b0, 1'b1));
    settle();
    write_alpha(17'd1);
    send_pair(pair(32'sh7fffffff, 32'sh80000000, 1'b0, 1'b0));
    send_pair(pair(32'sh80000000, 32'sh7fffffff, 1'b0, 1'b1));

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0: alpha_pick = AlphaReset;
        1: alpha_pick = 17'($urandom_range(1, 65535));
        2: alpha_pick = 17'(AlphaOne);
        3: alpha_pick = '0;
        4: alpha_pick = 17'($urandom);
        5: alpha_pick = 17'd65535;
        6: alpha_pick = 17'($urandom_range(1, 4096));
        default: alpha_pick = '1;
      endcase
      write_alpha(alpha_pick);
      tx_idle = (phase != 0);
      rx_idle = (phase != 0);
      if (phase == 4) hold_req = 1'b1;
      left = 0;
      for (int i = 0; i < PhaseItems; i++) begin
        if (left == 0) begin
          left = $urandom_range(1, 40);
          flavor = $urandom_range(0, 9);
          spread = $urandom_range(4, 30);
          cx = $urandom;
          cy = $urandom;
          first = 1'b1;
        end
        nx = $signed($urandom) >>> (32 - spread);
        ny = $signed($urandom) >>> (32 - spread);
        if (flavor < 2) begin
          sx = $urandom;
          sy = $urandom;
        end else if (flavor == 2) begin
          sx = corner($urandom_range(0, 3));
          sy = corner($urandom_range(0, 3));
        end else if (flavor < 7) begin
          sx = cx + nx;
          sy = cy + nx + (ny >>> 3);
        end else begin
          sx = cx + nx;
          sy = cy - nx + (ny >>> 3);
        end
        send_pair(pair(sx, sy, first || ($urandom_range(0, 99) < 2),
                       (left == 1) || ($urandom_range(0, 99) < 3)));
        first = 1'b0;
        left--;
      end
    end

    settle();
    repeat (30) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ewmc_pkg.sv
hw/rtl/ewmc_datapath.sv
hw/rtl/ewm_covariance_tracker.sv
dv/ewm_moment_checker.sv
dv/ewm_covariance_tracker_tb.sv
